// ----- src/bgc_pkg.sv -----
`default_nettype none
package bgc_pkg;

    localparam int NUM_INPUTS_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NODE_W     = 8;
    localparam int MASK_W     = 64;
    localparam int THR_W      = 16;
    localparam int TIME_W     = 32;
    localparam int INPUT_W    = 6;
    localparam int KIND_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd4;

    localparam logic [THR_W-1:0] HOLD_RST      = 16'd800;
    localparam logic [THR_W-1:0] LONG_HOLD_RST = 16'd2000;
    localparam logic [THR_W-1:0] GAP_RST       = 16'd400;

    localparam logic CMD_LEVEL = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_CLICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOLD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd3;

    localparam int IDX_MAX_W = INPUT_W;

    typedef struct packed {
        logic                 accept;
        logic                 lvl_exec;
        logic                 scan_issue;
        logic                 scan_eval;
        logic                 flush;
        logic [IDX_MAX_W-1:0] idx;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

// ----- src/bgc_ram.sv -----
`default_nettype none
module bgc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/bgc_ctrl.sv -----
`default_nettype none
module bgc_ctrl #(
    parameter int NUM_INPUTS = bgc_pkg::NUM_INPUTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_cmd,
    output logic                    o_busy,
    output bgc_pkg::t_ctrl_cmd      o_ctrl
);
    import bgc_pkg::*;

    localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_INPUTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LREAD,
        S_LEXEC,
        S_SCAN,
        S_SLAST,
        S_FLUSH
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_state = (i_cmd == CMD_TICK) ? S_SCAN : S_LREAD;
                end
            end
            S_LREAD: n_state = S_LEXEC;
            S_LEXEC: n_state = S_IDLE;
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_SLAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SLAST: n_state = S_FLUSH;
            S_FLUSH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        o_ctrl            = '0;
        o_ctrl.accept     = accept;
        o_ctrl.lvl_exec   = (r_state == S_LEXEC);
        o_ctrl.scan_issue = (r_state == S_SCAN);
        o_ctrl.scan_eval  = ((r_state == S_SCAN) && (r_idx != '0)) || (r_state == S_SLAST);
        o_ctrl.flush      = (r_state == S_FLUSH);
        o_ctrl.idx        = IDX_MAX_W'(r_idx);
    end
endmodule
`default_nettype wire

// ----- src/bgc_dp.sv -----
`default_nettype none
module bgc_dp #(
    parameter int NUM_INPUTS = bgc_pkg::NUM_INPUTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bgc_pkg::t_ctrl_cmd                i_ctrl,
    input  wire logic [bgc_pkg::INPUT_W-1:0]       i_input_number,
    input  wire logic                              i_level_active,
    input  wire logic [bgc_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic                              i_cfg_wr,
    input  wire logic [bgc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bgc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output logic      [bgc_pkg::KIND_W-1:0]        o_event_kind,
    output logic      [bgc_pkg::INPUT_W-1:0]       o_event_input,
    output logic      [bgc_pkg::NODE_W-1:0]        o_event_node,
    output logic                                   o_last_of_run
);
    import bgc_pkg::*;

    localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam logic [INPUT_W:0] NUM_IN_X = (INPUT_W + 1)'(NUM_INPUTS);

    logic [NODE_W-1:0]     r_node;
    logic [MASK_W-1:0]     r_mask;
    logic [THR_W-1:0]      r_hold, r_long, r_gap;

    logic [INPUT_W-1:0]    r_n;
    logic                  r_level;
    logic [TIME_W-1:0]     r_now;

    logic [NUM_INPUTS-1:0] r_wp, r_hr, r_lhr, r_cw;
    logic [NUM_INPUTS-1:0] n_wp, n_hr, n_lhr, n_cw;
    logic [NUM_INPUTS-1:0] en;

    logic [IW-1:0]         r_eval_idx;
    logic                  r_pend_vld, n_pend_vld;
    logic [IW-1:0]         r_pend_idx, n_pend_idx;

    logic                  n_strobe, n_last;
    logic [KIND_W-1:0]     n_kind;
    logic [INPUT_W-1:0]    n_input;

    logic [IW-1:0]         ni, scan_idx, click_raddr;
    logic                  lv_en;
    logic [TIME_W-1:0]     press_rd, click_rd, dur, gap_t;
    logic                  press_we, click_we;

    assign en       = r_mask[NUM_INPUTS-1:0];
    assign ni       = r_n[IW-1:0];
    assign scan_idx = i_ctrl.idx[IW-1:0];
    assign lv_en    = ({1'b0, r_n} < NUM_IN_X) && en[ni];
    assign dur      = r_now - press_rd;
    assign gap_t    = r_now - click_rd;
    assign click_raddr = i_ctrl.scan_issue ? scan_idx : ni;

    bgc_ram #(.WIDTH(TIME_W), .DEPTH(NUM_INPUTS)) u_press_ram (
        .i_clk   (i_clk),
        .i_we    (press_we),
        .i_waddr (ni),
        .i_wdata (r_now),
        .i_raddr (ni),
        .o_rdata (press_rd)
    );

    bgc_ram #(.WIDTH(TIME_W), .DEPTH(NUM_INPUTS)) u_click_ram (
        .i_clk   (i_clk),
        .i_we    (click_we),
        .i_waddr (ni),
        .i_wdata (r_now),
        .i_raddr (click_raddr),
        .o_rdata (click_rd)
    );

    always_comb begin
        n_wp       = r_wp;
        n_hr       = r_hr;
        n_lhr      = r_lhr;
        n_cw       = r_cw;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_strobe   = 1'b0;
        n_last     = 1'b0;
        n_kind     = KIND_CLICK;
        n_input    = r_n;
        press_we   = 1'b0;
        click_we   = 1'b0;

        if (i_ctrl.lvl_exec && lv_en) begin
            n_last = 1'b1;
            if (r_wp[ni] == r_level) begin
                if (r_level) begin
                    if (!r_lhr[ni] && (dur >= {16'd0, r_long})) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_LONG;
                        n_lhr[ni] = 1'b1;
                        n_cw[ni]  = 1'b0;
                    end else if (!r_hr[ni] && (dur >= {16'd0, r_hold})) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_HOLD;
                        n_hr[ni] = 1'b1;
                        n_cw[ni] = 1'b0;
                    end
                end
            end else if (r_level) begin
                if (r_cw[ni] && (gap_t <= {16'd0, r_gap})) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_DOUBLE;
                    n_cw[ni] = 1'b0;
                end
                press_we  = 1'b1;
                n_hr[ni]  = 1'b0;
                n_lhr[ni] = 1'b0;
                n_wp[ni]  = 1'b1;
            end else begin
                n_wp[ni] = 1'b0;
                if (dur >= {16'd0, r_hold}) begin
                    if (!r_hr[ni]) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_HOLD;
                    end
                    n_cw[ni] = 1'b0;
                end else begin
                    n_cw[ni] = 1'b1;
                    click_we = 1'b1;
                end
            end
        end

        if (i_ctrl.scan_eval && en[r_eval_idx] && r_cw[r_eval_idx]
                && (gap_t > {16'd0, r_gap})) begin
            n_cw[r_eval_idx] = 1'b0;
            if (r_pend_vld) begin
                n_strobe = 1'b1;
                n_kind   = KIND_CLICK;
                n_input  = INPUT_W'(r_pend_idx);
            end
            n_pend_vld = 1'b1;
            n_pend_idx = r_eval_idx;
        end

        if (i_ctrl.flush) begin
            n_pend_vld = 1'b0;
            if (r_pend_vld) begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_kind   = KIND_CLICK;
                n_input  = INPUT_W'(r_pend_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node     <= '0;
            r_mask     <= '0;
            r_hold     <= HOLD_RST;
            r_long     <= LONG_HOLD_RST;
            r_gap      <= GAP_RST;
            r_wp       <= '0;
            r_hr       <= '0;
            r_lhr      <= '0;
            r_cw       <= '0;
            r_pend_vld <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    REG_NODE:      r_node <= i_cfg_data[NODE_W-1:0];
                    REG_ENABLE:    r_mask <= i_cfg_data[MASK_W-1:0];
                    REG_HOLD:      r_hold <= i_cfg_data[THR_W-1:0];
                    REG_LONG_HOLD: r_long <= i_cfg_data[THR_W-1:0];
                    REG_GAP:       r_gap  <= i_cfg_data[THR_W-1:0];
                    default:       ;
                endcase
            end
            r_wp       <= n_wp;
            r_hr       <= n_hr;
            r_lhr      <= n_lhr;
            r_cw       <= n_cw;
            r_pend_vld <= n_pend_vld;
            o_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_n     <= i_input_number;
            r_level <= i_level_active;
            r_now   <= i_now_ms;
        end
        if (i_ctrl.scan_issue) begin
            r_eval_idx <= scan_idx;
        end
        r_pend_idx    <= n_pend_idx;
        o_event_kind  <= n_kind;
        o_event_input <= n_input;
        o_event_node  <= r_node;
        o_last_of_run <= n_last;
    end
endmodule
`default_nettype wire

// ----- src/button_gesture_classifier_unit.sv -----
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+--------------------------------------
// item     | in        | start && !busy               | i_cmd, i_input_number, i_level_active,
//          |           |                              | i_now_ms
// result   | out       | o_strobe, one cycle each     | o_event_kind, o_event_input,
//          |           |                              | o_event_node, o_last_of_run
// config   | in        | i_cfg_valid && o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A level item steps through accept, read of the stamp RAMs, then update and emit.
// A tick item does one click stamp RAM read per input, each pipelined ahead of its check,
// then a flush of the last pending click.
// Results appear in the cycle after the update that makes them; the receiver cannot stall.
// Reset is synchronous; all per-input flags clear at once, no clearing pass.
// Config is always ready; a write lands in its register directly, not deferred to the next item.
`default_nettype none
module button_gesture_classifier_unit #(
    parameter int NUM_INPUTS = bgc_pkg::NUM_INPUTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cmd,
    input  wire logic [bgc_pkg::INPUT_W-1:0]       i_input_number,
    input  wire logic                              i_level_active,
    input  wire logic [bgc_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bgc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bgc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output logic      [bgc_pkg::KIND_W-1:0]        o_event_kind,
    output logic      [bgc_pkg::INPUT_W-1:0]       o_event_input,
    output logic      [bgc_pkg::NODE_W-1:0]        o_event_node,
    output logic                                   o_last_of_run
);
    import bgc_pkg::*;

    t_ctrl_cmd ctrl;

    assign o_cfg_ready = 1'b1;

    bgc_ctrl #(.NUM_INPUTS(NUM_INPUTS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    bgc_dp #(.NUM_INPUTS(NUM_INPUTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_input_number (i_input_number),
        .i_level_active (i_level_active),
        .i_now_ms       (i_now_ms),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_event_kind   (o_event_kind),
        .o_event_input  (o_event_input),
        .o_event_node   (o_event_node),
        .o_last_of_run  (o_last_of_run)
    );
endmodule
`default_nettype wire

// ----- src/bgc_chk.sv -----
`default_nettype none
module bgc_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_cmd,
    input wire logic o_strobe,
    input wire logic o_last_of_run
);
    import bgc_pkg::*;

    logic accept;
    assign accept = start && !busy;

    a_strobe_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without work in progress");

    a_no_strobe_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_strobe)
        else $error("result strobe right after accept");

    a_level_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_LEVEL)) |-> ##3 (!o_strobe || o_last_of_run))
        else $error("level item result not marked last");

    a_idle_strobe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !busy) |-> o_last_of_run)
        else $error("result while idle not marked last");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_of_run) |=> !o_strobe)
        else $error("result follows last of run");
endmodule

bind button_gesture_classifier_unit bgc_chk u_bgc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_cmd         (i_cmd),
    .o_strobe      (o_strobe),
    .o_last_of_run (o_last_of_run)
);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_WAIT = NUM_INPUTS_DEF + 16;

    typedef struct packed {
        logic              cmd;
        logic [INPUT_W-1:0] num;
        logic              lvl;
        logic [TIME_W-1:0] now;
    } t_sample;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INPUT_W-1:0] num;
        logic [NODE_W-1:0]  node;
        logic               last;
    } t_gesture;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_sample               cur = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic [KIND_W-1:0]     o_event_kind;
    logic [INPUT_W-1:0]    o_event_input;
    logic [NODE_W-1:0]     o_event_node;
    logic                  o_last_of_run;

    t_sample     samples_todo[$];
    t_gesture    events_due[$];
    int          samples_made = 0;
    int          err_count = 0;
    int          hold_off = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;
    logic [TIME_W-1:0] t_ms = '0;

    logic [NODE_W-1:0] cfg_node = '0;
    logic [MASK_W-1:0] cfg_mask = '0;
    logic [THR_W-1:0]  cfg_hold = HOLD_RST;
    logic [THR_W-1:0]  cfg_long = LONG_HOLD_RST;
    logic [THR_W-1:0]  cfg_gap = GAP_RST;

    bit [NUM_INPUTS_DEF-1:0] pressed = '0;
    bit [NUM_INPUTS_DEF-1:0] hold_done = '0;
    bit [NUM_INPUTS_DEF-1:0] long_sent = '0;
    bit [NUM_INPUTS_DEF-1:0] waiting = '0;
    logic [TIME_W-1:0] press_t [NUM_INPUTS_DEF] = '{default: '0};
    logic [TIME_W-1:0] click_t [NUM_INPUTS_DEF] = '{default: '0};

    button_gesture_classifier_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (cur.cmd),
        .i_input_number (cur.num),
        .i_level_active (cur.lvl),
        .i_now_ms       (cur.now),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_event_kind   (o_event_kind),
        .o_event_input  (o_event_input),
        .o_event_node   (o_event_node),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void classify_item(input t_sample s);
        t_gesture           run[$];
        logic [TIME_W-1:0]  dur;
        logic [INPUT_W-1:0] n;
        n = s.num;
        if (s.cmd == CMD_TICK) begin
            for (int i = 0; i < NUM_INPUTS_DEF; i++) begin
                if (cfg_mask[i] && waiting[i] && ((s.now - click_t[i]) > cfg_gap)) begin
                    run.push_back(t_gesture'{KIND_CLICK, INPUT_W'(i), cfg_node, 1'b0});
                    waiting[i] = 1'b0;
                    click_t[i] = '0;
                end
            end
        end else if (cfg_mask[n]) begin
            if (pressed[n] == s.lvl) begin
                if (s.lvl) begin
                    dur = s.now - press_t[n];
                    if (!long_sent[n] && dur >= cfg_long) begin
                        run.push_back(t_gesture'{KIND_LONG, n, cfg_node, 1'b0});
                        long_sent[n] = 1'b1;
                        waiting[n] = 1'b0;
                    end else if (!hold_done[n] && dur >= cfg_hold) begin
                        run.push_back(t_gesture'{KIND_HOLD, n, cfg_node, 1'b0});
                        hold_done[n] = 1'b1;
                        waiting[n] = 1'b0;
                    end
                end
            end else if (s.lvl) begin
                if (waiting[n] && ((s.now - click_t[n]) <= cfg_gap)) begin
                    run.push_back(t_gesture'{KIND_DOUBLE, n, cfg_node, 1'b0});
                    waiting[n] = 1'b0;
                    click_t[n] = '0;
                end
                press_t[n] = s.now;
                hold_done[n] = 1'b0;
                long_sent[n] = 1'b0;
                pressed[n] = 1'b1;
            end else begin
                dur = s.now - press_t[n];
                pressed[n] = 1'b0;
                if (dur >= cfg_hold) begin
                    if (!hold_done[n])
                        run.push_back(t_gesture'{KIND_HOLD, n, cfg_node, 1'b0});
                    waiting[n] = 1'b0;
                    click_t[n] = '0;
                end else begin
                    waiting[n] = 1'b1;
                    click_t[n] = s.now;
                end
            end
        end
        if (run.size() != 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[k])
            events_due.push_back(run[k]);
    endfunction

    // stimulus helpers
    function automatic void queue_sample(input t_sample s);
        samples_todo.push_back(s);
        samples_made++;
    endfunction

    function automatic void add_level(input logic [INPUT_W-1:0] n, input logic lvl);
        queue_sample(t_sample'{CMD_LEVEL, n, lvl, t_ms});
    endfunction

    function automatic void add_tick();
        t_sample s;
        s.cmd = CMD_TICK;
        s.num = INPUT_W'($urandom_range(0, 63));
        s.lvl = 1'($urandom_range(0, 1));
        s.now = t_ms;
        queue_sample(s);
    endfunction

    function automatic void level_at(input logic [TIME_W-1:0] t, input logic [INPUT_W-1:0] n,
                                     input logic lvl);
        t_ms = t;
        add_level(n, lvl);
    endfunction

    function automatic void tick_at(input logic [TIME_W-1:0] t);
        t_ms = t;
        add_tick();
    endfunction

    function automatic logic [TIME_W-1:0] near(input logic [THR_W-1:0] thr);
        logic [TIME_W-1:0] w;
        w = {16'b0, thr};
        case ($urandom_range(0, 3))
            0: return w;
            1: return (w == 0) ? w : w - 1;
            2: return w + 1;
            default: return $urandom_range(0, w + w / 2 + 2);
        endcase
    endfunction

    function automatic logic [INPUT_W-1:0] pick_input();
        logic [INPUT_W-1:0] n;
        n = INPUT_W'($urandom_range(0, 63));
        for (int k = 0; k < 8 && !cfg_mask[n]; k++)
            n = INPUT_W'($urandom_range(0, 63));
        return n;
    endfunction

    function automatic void burst(input int k);
        logic [INPUT_W-1:0] n;
        for (int j = 0; j < k; j++) begin
            n = (k == NUM_INPUTS_DEF) ? INPUT_W'(j) : pick_input();
            add_level(n, 1'b1);
            t_ms += (cfg_hold == 0) ? 0 : $urandom_range(0, cfg_hold - 1);
            add_level(n, 1'b0);
            t_ms += $urandom_range(0, 5);
        end
        t_ms += (k == NUM_INPUTS_DEF) ? cfg_gap + 1 : near(cfg_gap);
        add_tick();
    endfunction

    function automatic void add_gesture();
        logic [INPUT_W-1:0] n;
        t_sample            s;
        n = pick_input();
        case ($urandom_range(0, 9))
            0, 1: begin
                add_level(n, 1'b1);
                t_ms += near(cfg_hold);
                add_level(n, 1'b0);
                if ($urandom_range(0, 1)) begin
                    t_ms += near(cfg_gap);
                    add_tick();
                end
            end
            2, 3: begin
                add_level(n, 1'b1);
                t_ms += $urandom_range(0, cfg_hold);
                add_level(n, 1'b0);
                t_ms += near(cfg_gap);
                add_level(n, 1'b1);
                t_ms += $urandom_range(0, cfg_hold);
                add_level(n, 1'b0);
            end
            4, 5: begin
                add_level(n, 1'b1);
                repeat ($urandom_range(1, 4)) begin
                    t_ms += near($urandom_range(0, 1) ? cfg_hold : cfg_long);
                    add_level(n, 1'b1);
                end
                if ($urandom_range(0, 3) != 0) begin
                    t_ms += near(cfg_hold);
                    add_level(n, 1'b0);
                end
            end
            6: burst($urandom_range(2, 8));
            7: begin
                t_ms += near(cfg_gap);
                add_tick();
            end
            8: begin
                s.cmd = 1'($urandom_range(0, 1));
                s.num = INPUT_W'($urandom_range(0, 63));
                s.lvl = 1'($urandom_range(0, 1));
                s.now = $urandom;
                queue_sample(s);
            end
            default: add_level(INPUT_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        endcase
        t_ms += $urandom_range(0, 60);
    endfunction

    function automatic void fill(input int target);
        samples_made = 0;
        while (samples_made < target)
            add_gesture();
    endfunction

    function automatic void directed_items();
        level_at(32'd0, 6'd10, 1'b1);
        level_at(32'd1000, 6'd0, 1'b1);
        level_at(32'd1799, 6'd0, 1'b1);
        level_at(32'd1800, 6'd0, 1'b1);
        level_at(32'd3000, 6'd0, 1'b1);
        level_at(32'd3200, 6'd0, 1'b0);
        level_at(32'd5000, 6'd63, 1'b1);
        level_at(32'd5100, 6'd63, 1'b0);
        level_at(32'd5400, 6'd63, 1'b1);
        level_at(32'd5450, 6'd63, 1'b0);
        tick_at(32'd5850);
        tick_at(32'd5851);
        level_at(32'd6000, 6'd1, 1'b1);
        level_at(32'd7000, 6'd1, 1'b0);
        level_at(32'd7100, 6'd1, 1'b0);
        level_at(32'd8000, 6'd2, 1'b1);
        level_at(32'd10000, 6'd2, 1'b1);
        level_at(32'd10100, 6'd2, 1'b1);
        level_at(32'd10200, 6'd2, 1'b0);
        level_at(32'hFFFF_FF00, 6'd3, 1'b1);
        level_at(32'h0000_0010, 6'd3, 1'b0);
        level_at(32'h0000_0020, 6'd4, 1'b1);
        level_at(32'h0000_0040, 6'd4, 1'b0);
        tick_at(32'h0000_0300);
        level_at(32'hFFFF_FFFF, 6'd6, 1'b1);
        level_at(32'hFFFF_FFFF, 6'd6, 1'b0);
        level_at(32'hFFFF_FFFF, 6'd6, 1'b1);
        level_at(32'hFFFF_FFFF, 6'd6, 1'b0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pad_hi(input logic [CFG_DATA_W-1:0] v,
                                                     input int w);
        return ({$urandom, $urandom} << w) | v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_NODE:      cfg_node = val[NODE_W-1:0];
            REG_ENABLE:    cfg_mask = val[MASK_W-1:0];
            REG_HOLD:      cfg_hold = val[THR_W-1:0];
            REG_LONG_HOLD: cfg_long = val[THR_W-1:0];
            REG_GAP:       cfg_gap = val[THR_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [NODE_W-1:0] node, input logic [MASK_W-1:0] mask,
                            input logic [THR_W-1:0] hold, input logic [THR_W-1:0] long_thr,
                            input logic [THR_W-1:0] gap);
        write_reg(REG_NODE, pad_hi(CFG_DATA_W'(node), NODE_W));
        write_reg(REG_ENABLE, mask);
        write_reg(REG_HOLD, pad_hi(CFG_DATA_W'(hold), THR_W));
        write_reg(REG_LONG_HOLD, pad_hi(CFG_DATA_W'(long_thr), THR_W));
        write_reg(REG_GAP, pad_hi(CFG_DATA_W'(gap), THR_W));
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        while ((samples_todo.size() != 0 || start || busy || events_due.size() != 0)
               && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // driver: launch the next item once the slot is free, with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            hold_off <= 0;
        end else begin
            if (start && !busy)
                classify_item(cur);
            if (!start || !busy) begin
                if (hold_off != 0) begin
                    hold_off <= hold_off - 1;
                    start <= 1'b0;
                end else if (samples_todo.size() != 0) begin
                    cur <= samples_todo.pop_front();
                    start <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0)
                        hold_off <= $urandom_range(1, 10);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_gesture want;
        if (i_rst_n && o_strobe) begin
            if (events_due.size() == 0) begin
                $error("unexpected event: kind %0d input %0d", o_event_kind, o_event_input);
                err_count++;
            end else begin
                want = events_due.pop_front();
                if (o_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
                    err_count++;
                end
                if (o_event_input !== want.num) begin
                    $error("event_input: expected %0d, got %0d", want.num, o_event_input);
                    err_count++;
                end
                if (o_event_node !== want.node) begin
                    $error("event_node: expected %0d, got %0d", want.node, o_event_node);
                    err_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_last_of_run);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_NODE, pad_hi(CFG_DATA_W'(8'hA5), NODE_W));
        write_reg(REG_ENABLE, 64'h8000_0000_0000_007F);
        directed_items();
        settle();

        set_regs(8'h3C, '1, 16'd300, 16'd900, 16'd150);
        for (int j = 1; j <= 3; j++)
            write_reg(REG_GAP + CFG_IDX_W'(j), {$urandom, $urandom});
        t_ms = $urandom;
        burst(NUM_INPUTS_DEF);
        fill(25);
        settle();

        set_regs(8'hFF, {$urandom, $urandom} | 64'h1, 16'd0, 16'd0, 16'd0);
        t_ms = $urandom;
        fill(20);
        settle();

        set_regs(8'h00, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        t_ms = 32'hFFFF_0000;
        fill(20);
        settle();

        set_regs(NODE_W'($urandom_range(0, 255)), {$urandom, $urandom},
                 THR_W'($urandom_range(1, 1500)), THR_W'($urandom_range(1, 3000)),
                 THR_W'($urandom_range(1, 800)));
        t_ms = $urandom;
        fill(25);
        settle();

        set_regs(NODE_W'($urandom_range(0, 255)), {$urandom, $urandom} | 64'hFFFF_0000_0000_FFFF,
                 THR_W'($urandom_range(1, 1500)), THR_W'($urandom_range(1, 3000)),
                 THR_W'($urandom_range(1, 800)));
        calm = 1'b1;
        t_ms = $urandom;
        fill(30);
        settle();

        if (events_due.size() != 0) begin
            $error("%0d expected events never arrived", events_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
